>>> sv/awc_pkg.sv
package awc_pkg;

  typedef struct packed {
    logic        timed_out;
    logic        is_manifest;
    logic [23:0] rtt_us;
    logic [31:0] pending_us;
  } in_req_t;

  typedef struct packed {
    logic [31:0] window_now;
    logic [1:0]  phase_now;
    logic [17:0] interval_us;
    logic        reschedule;
    logic        send_now;
  } out_req_t;

  localparam logic [1:0] PH_SLOW = 2'd0;
  localparam logic [1:0] PH_ADD  = 2'd1;
  localparam logic [1:0] PH_MD   = 2'd2;

  // divider jobs: 1000/rtt, inc/window, 1000000/window
  typedef enum logic [1:0] {
    OP_INC,
    OP_ADD,
    OP_IVL
  } div_op_e;

  typedef struct packed {
    logic    load_in;
    logic    pre;
    logic    div_load;
    div_op_e div_op;
    logic    div_step;
    logic    take_inc;
    logic    set_slow;
    logic    set_add;
    logic    grow;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic timed_out;
    logic slow;
  } dp_sts_t;

  // two quotient bits per step; dividend length rounded up to even
  function automatic int unsigned div_steps(input div_op_e op, input int unsigned frac);
    int unsigned len;
    case (op)
      OP_INC:  len = 10 + frac;
      OP_ADD:  len = 32 + frac;
      default: len = 20 + frac;
    endcase
    return (len + 1) >> 1;
  endfunction

endpackage

>>> sv/awc_ctrl.sv
module awc_ctrl #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  awc_pkg::dp_sts_t sts_i,
  output awc_pkg::dp_cmd_t cmd_o
);
  import awc_pkg::*;

  localparam int unsigned MAX_STEPS = div_steps(OP_ADD, FRAC_BITS);
  localparam int unsigned CW        = $clog2(MAX_STEPS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRE  = 3'd1;
  localparam logic [2:0] ST_LD   = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_POST = 3'd4;
  localparam logic [2:0] ST_GROW = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]    state_q, state_d;
  div_op_e       op_q, op_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.div_op = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_PRE;
        end
      end
      ST_PRE: begin
        cmd_o.pre = 1'b1;
        op_d      = sts_i.timed_out ? OP_IVL : OP_INC;
        state_d   = ST_LD;
      end
      ST_LD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = CW'(div_steps(op_q, FRAC_BITS) - 1);
        state_d        = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_POST;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_POST: begin
        unique case (op_q)
          OP_INC: begin
            cmd_o.take_inc = 1'b1;
            if (sts_i.slow) begin
              cmd_o.set_slow = 1'b1;
              state_d        = ST_GROW;
            end else begin
              op_d    = OP_ADD;
              state_d = ST_LD;
            end
          end
          OP_ADD: begin
            cmd_o.take_inc = 1'b1;
            cmd_o.set_add  = 1'b1;
            state_d        = ST_GROW;
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_GROW: begin
        cmd_o.grow = 1'b1;
        op_d       = OP_IVL;
        state_d    = ST_LD;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_INC;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == ST_PRE)
    else $error("accepted request did not start processing");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cnt_q == '0) |=> state_q == ST_POST)
    else $error("divider run did not end on count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && out_stall_i) |-> !cmd_o.out_load)
    else $error("held result overwritten");

endmodule

>>> sv/awc_dp.sv
module awc_dp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  awc_pkg::in_req_t  in_req_i,
  input  awc_pkg::dp_cmd_t  cmd_i,
  output awc_pkg::dp_sts_t  sts_o,
  output awc_pkg::out_req_t out_req_o
);
  import awc_pkg::*;

  localparam int unsigned DVW     = 2 * div_steps(OP_ADD, FRAC_BITS);
  localparam logic [31:0] WIN_RST = 32'd4 << FRAC_BITS;
  localparam logic [DVW-1:0] INC_NUM = DVW'(1000) << FRAC_BITS;
  localparam logic [DVW-1:0] IVL_NUM = DVW'(1000000) << FRAC_BITS;

  function automatic logic [32:0] div_bit(input logic [31:0] r, input logic b,
                                          input logic [31:0] d);
    logic [32:0] t;
    logic [32:0] s;
    t = {r, b};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, s[31:0]};
    end
    return {1'b0, t[31:0]};
  endfunction

  logic [31:0]    max_win_q, win_q, thr_q, inc_q;
  logic [1:0]     phase_q;
  logic [15:0]    ign_q;
  logic           resched_q;
  in_req_t        in_q;
  out_req_t       out_q;
  logic [31:0]    div_r_q, div_d_q;
  logic [DVW-1:0] div_q_q;

  logic           counted;
  logic [31:0]    win_ip, half, shrunk;
  logic [15:0]    ign_set, ign_mid, ign_next;
  logic [DVW-1:0] dvd;
  logic [31:0]    dvs;
  logic [32:0]    s1, s2;
  logic [31:0]    q_sat32, grown, capped;
  logic [32:0]    sum;
  logic [17:0]    ivl;
  logic           resched_fin;

  // timeout handling and ignore counter
  assign counted  = in_q.timed_out && (phase_q != PH_MD) && (ign_q == '0);
  assign win_ip   = win_q >> FRAC_BITS;
  assign ign_set  = (|win_ip[31:16]) ? 16'hFFFF : win_ip[15:0];
  assign half     = win_q >> 1;
  assign shrunk   = (half < WIN_RST) ? WIN_RST : half;
  assign ign_mid  = counted ? ign_set : ign_q;
  assign ign_next = (ign_mid != '0) ? ign_mid - 1'b1 : ign_mid;

  // divider operands
  always_comb begin
    unique case (cmd_i.div_op)
      OP_INC: begin
        dvd = INC_NUM;
        dvs = {8'd0, in_q.rtt_us};
      end
      OP_ADD: begin
        dvd = {{(DVW-32){1'b0}}, inc_q} << FRAC_BITS;
        dvs = win_q;
      end
      default: begin
        dvd = IVL_NUM;
        dvs = win_q;
      end
    endcase
  end

  assign s1 = div_bit(div_r_q, div_q_q[DVW-1], div_d_q);
  assign s2 = div_bit(s1[31:0], div_q_q[DVW-2], div_d_q);

  // a zero divisor saturates the increment to all ones
  assign q_sat32 = ((|div_q_q[DVW-1:32]) || (div_d_q == '0)) ? 32'hFFFF_FFFF :
                   div_q_q[31:0];
  assign ivl     = (|div_q_q[DVW-1:18]) ? 18'h3FFFF : div_q_q[17:0];

  assign sum    = {1'b0, win_q} + {1'b0, inc_q};
  assign grown  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign capped = (grown > max_win_q) ? max_win_q : grown;

  assign resched_fin = resched_q || (!in_q.timed_out && (in_q.pending_us > {14'd0, ivl}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_win_q <= WIN_RST;
      win_q     <= WIN_RST;
      thr_q     <= 32'hFFFF_FFFF;
      phase_q   <= PH_SLOW;
      ign_q     <= '0;
      resched_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_win_q <= cfg_wdata_i;
      end
      if (cmd_i.pre) begin
        ign_q     <= ign_next;
        resched_q <= counted;
        if (counted) begin
          win_q   <= shrunk;
          thr_q   <= shrunk;
          phase_q <= PH_MD;
        end
      end
      if (cmd_i.set_slow) begin
        phase_q <= PH_SLOW;
      end
      if (cmd_i.set_add) begin
        phase_q <= PH_ADD;
      end
      if (cmd_i.grow) begin
        win_q <= capped;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_req_i;
    end
    if (cmd_i.div_load) begin
      div_r_q <= '0;
      div_d_q <= dvs;
      div_q_q <= dvd << (DVW - 2 * div_steps(cmd_i.div_op, FRAC_BITS));
    end else if (cmd_i.div_step) begin
      div_r_q <= s2[31:0];
      div_q_q <= {div_q_q[DVW-3:0], s1[32], s2[32]};
    end
    if (cmd_i.take_inc) begin
      inc_q <= q_sat32;
    end
    if (cmd_i.out_load) begin
      out_q.window_now  <= win_q;
      out_q.phase_now   <= phase_q;
      out_q.interval_us <= ivl;
      out_q.reschedule  <= resched_fin;
      out_q.send_now    <= in_q.is_manifest;
    end
  end

  assign sts_o.timed_out = in_q.timed_out;
  assign sts_o.slow      = win_q < thr_q;
  assign out_req_o       = out_q;

  a_md_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MD) |-> (win_q >= WIN_RST))
    else $error("window below floor after decrease");

  a_md_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MD) |-> (thr_q == win_q))
    else $error("threshold differs from window after decrease");

endmodule

>>> sv/aimd_window_controller.sv
// AIMD congestion window controller with slow start.
// Input channel: in_valid_i / in_stall_o carry one reply event request
// (timeout flag, manifest flag, RTT estimate, time to next send).
// Output channel: out_valid_o / out_stall_i carry one result request per
// event: window, phase, send interval, reschedule and send-now flags.
// Config: cfg_we_i writes max_window from cfg_wdata_i; the current window
// is not touched by the write.
// One event is processed at a time through a shared radix-4 restoring
// divider (two quotient bits per cycle). A timeout runs only the interval
// division; slow start first divides 1000 by the RTT for the increment, and
// additive increase also divides that increment by the window. The next
// event is accepted in the cycle after the result is registered, even if
// that result is still held by a stalled receiver; the block only waits at
// the end of processing when the output register is still full.
// Reset (async, active low) sets max_window and the window to 4.0, the
// threshold to all ones, the phase to slow start and the ignore count to 0.
module aimd_window_controller #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  awc_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output awc_pkg::out_req_t out_req_o
);
  import awc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  awc_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  awc_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_req_o  (out_req_o)
  );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import awc_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 366;
  localparam logic [31:0] WIN_FOUR = 32'd4 << FRAC;

  class aimd_tracker;
    logic [31:0] max_window;
    logic [31:0] window;
    logic [31:0] ssthresh;
    logic [1:0]  phase;
    logic [15:0] ignore_cnt;
    out_req_t    expected_updates[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned requests;
    int unsigned counted_timeouts;
    int unsigned slow_updates;
    int unsigned add_updates;

    function new();
      max_window = WIN_FOUR;
      window = WIN_FOUR;
      ssthresh = '1;
      phase = PH_SLOW;
      ignore_cnt = '0;
      mismatches = 0;
      checked = 0;
      requests = 0;
      counted_timeouts = 0;
      slow_updates = 0;
      add_updates = 0;
    endfunction

    function logic [31:0] sat32(logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function logic [17:0] send_interval(logic [31:0] w);
      logic [63:0] q;
      if (w == 0) return 18'h3FFFF;
      q = (64'd1000000 << FRAC) / w;
      return (q > 64'd262143) ? 18'h3FFFF : q[17:0];
    endfunction

    function logic [17:0] interval_now();
      return send_interval(window);
    endfunction

    function void set_max_window(logic [31:0] v);
      max_window = v;
    endfunction

    function void note_event(in_req_t r);
      logic [63:0] inc;
      logic [31:0] ip;
      logic        resched;
      out_req_t    e;
      resched = 1'b0;
      requests++;
      if (r.timed_out && phase != PH_MD && ignore_cnt == 0) begin
        ip = window >> FRAC;
        ignore_cnt = (ip > 32'hFFFF) ? 16'hFFFF : ip[15:0];
        window = ((window >> 1) < WIN_FOUR) ? WIN_FOUR : (window >> 1);
        ssthresh = window;
        phase = PH_MD;
        resched = 1'b1;
        counted_timeouts++;
      end
      if (ignore_cnt != 0) ignore_cnt--;
      if (!r.timed_out) begin
        inc = (r.rtt_us == 0) ? 64'hFFFF_FFFF : sat32((64'd1000 << FRAC) / r.rtt_us);
        if (window < ssthresh) begin
          phase = PH_SLOW;
          slow_updates++;
        end else begin
          inc = (window == 0) ? 64'hFFFF_FFFF : sat32((inc << FRAC) / window);
          phase = PH_ADD;
          add_updates++;
        end
        window = sat32({32'd0, window} + inc);
        if (window > max_window) window = max_window;
        if (r.pending_us > send_interval(window)) resched = 1'b1;
      end
      e.window_now = window;
      e.phase_now = phase;
      e.interval_us = send_interval(window);
      e.reschedule = resched;
      e.send_now = r.is_manifest;
      expected_updates.push_back(e);
    endfunction

    function void check_update(out_req_t a);
      out_req_t e;
      checked++;
      if (expected_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: win=%h ph=%0d ivl=%0d rs=%b sn=%b",
                   $realtime, a.window_now, a.phase_now, a.interval_us, a.reschedule,
                   a.send_now);
        return;
      end
      e = expected_updates.pop_front();
      if (a.window_now !== e.window_now || a.phase_now !== e.phase_now ||
          a.interval_us !== e.interval_us || a.reschedule !== e.reschedule ||
          a.send_now !== e.send_now) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result %0d mismatch", $realtime, checked);
          $display("  exp: win=%h ph=%0d ivl=%0d rs=%b sn=%b", e.window_now, e.phase_now,
                   e.interval_us, e.reschedule, e.send_now);
          $display("  got: win=%h ph=%0d ivl=%0d rs=%b sn=%b", a.window_now, a.phase_now,
                   a.interval_us, a.reschedule, a.send_now);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  in_req_t     in_req;
  logic        out_valid;
  logic        out_stall;
  out_req_t    out_req;
  bit          hold_req;
  int unsigned cfg_settings;
  aimd_tracker sb;

  aimd_window_controller #(.FRAC_BITS(FRAC)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o  (out_req)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_update(out_req);
  end

  // receiver: stretches of different stall patterns, one long hold on request
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned cyc;
    out_stall <= 1'b0;
    cyc = 0;
    forever begin
      if (hold_req) begin
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 150);
        repeat (span) begin
          @(posedge clk);
          cyc++;
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 6);
            default: out_stall <= (cyc % 5 == 0);
          endcase
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic in_req_t mk_event(bit tmo, bit man, logic [23:0] rtt,
                                       logic [31:0] pend);
    in_req_t r;
    r.timed_out = tmo;
    r.is_manifest = man;
    r.rtt_us = rtt;
    r.pending_us = pend;
    return r;
  endfunction

  task automatic offer_request(input in_req_t r);
    in_req <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_event(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_updates.size() != 0) @(posedge clk);
  endtask

  task automatic write_max_window(input logic [31:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_max_window(v);
    cfg_settings++;
  endtask

  task automatic run_random_events(input int unsigned n);
    int unsigned burst_left;
    int unsigned gap;
    int unsigned sel;
    logic [23:0] rtt;
    logic [31:0] pend;
    bit          tmo;
    bit          man;
    burst_left = 0;
    repeat (n) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      tmo = ($urandom_range(0, 99) < 12);
      man = ($urandom_range(0, 9) == 0);
      sel = $urandom_range(0, 19);
      if (sel == 0) rtt = '0;
      else if (sel < 6) rtt = 24'($urandom_range(1, 50));
      else if (sel < 14) rtt = 24'($urandom_range(50, 5000));
      else if (sel < 18) rtt = 24'($urandom_range(5000, 1000000));
      else rtt = 24'($urandom);
      sel = $urandom_range(0, 9);
      if (sel == 0) pend = $urandom;
      else if (sel == 1) pend = sb.interval_now() + $urandom_range(0, 4) - 2;
      else pend = $urandom_range(0, 300000);
      offer_request(mk_event(tmo, man, rtt, pend));
    end
    drain();
  endtask

  initial begin
    logic [31:0] phase_max[5];
    sb = new();
    hold_req = 1'b0;
    cfg_settings = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_req <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // saturating growth, then tiny additive steps at the top of the range
    write_max_window(32'hFFFF_FFFF);
    offer_request(mk_event(1'b0, 1'b1, 24'd0, 32'd0));
    offer_request(mk_event(1'b0, 1'b0, 24'hFF_FFFF, 32'hFFFF_FFFF));
    offer_request(mk_event(1'b0, 1'b0, 24'd1, 32'd0));
    drain();
    // cap below the window, floor of 4, uncounted and ignored timeouts
    write_max_window(WIN_FOUR);
    offer_request(mk_event(1'b0, 1'b0, 24'd1, 32'd15259));
    offer_request(mk_event(1'b0, 1'b1, 24'd500, 32'd250000));
    offer_request(mk_event(1'b1, 1'b0, 24'd0, 32'hFFFF_FFFF));
    offer_request(mk_event(1'b1, 1'b1, 24'd1000, 32'd0));
    offer_request(mk_event(1'b0, 1'b0, 24'd2000, 32'd1));
    offer_request(mk_event(1'b1, 1'b0, 24'd10, 32'd0));
    offer_request(mk_event(1'b1, 1'b1, 24'hFF_FFFF, 32'hFFFF_FFFF));
    offer_request(mk_event(1'b0, 1'b0, 24'd0, 32'd250001));
    drain();
    offer_request(mk_event(1'b1, 1'b0, 24'd5, 32'd0));
    drain();
    write_max_window(32'd64 << FRAC);
    offer_request(mk_event(1'b0, 1'b0, 24'd1, 32'hFFFF_FFFF));
    offer_request(mk_event(1'b0, 1'b1, 24'd0, 32'd15625));
    offer_request(mk_event(1'b0, 1'b0, 24'd100, 32'd15626));
    offer_request(mk_event(1'b1, 1'b0, 24'd100, 32'd0));
    offer_request(mk_event(1'b0, 1'b0, 24'd3, 32'd100000));
    offer_request(mk_event(1'b0, 1'b0, 24'h80_0000, 32'h8000_0000));
    drain();

    phase_max[0] = WIN_FOUR;
    phase_max[1] = (32'd96 << FRAC) | 32'h8000;
    phase_max[2] = $urandom_range(WIN_FOUR, 32'd128 << FRAC);
    phase_max[3] = 32'd32 << FRAC;
    phase_max[4] = 32'hFFFF_FFFF;
    for (int p = 0; p < 5; p++) begin
      write_max_window(phase_max[p]);
      if (p == 1) hold_req = 1'b1;
      run_random_events(PHASE_ITEMS);
    end

    repeat (100) @(posedge clk);
    $display("covered %0d requests over %0d max_window settings, %0d results checked",
             sb.requests, cfg_settings, sb.checked);
    $display("counted timeouts %0d, slow-start updates %0d, additive updates %0d",
             sb.counted_timeouts, sb.slow_updates, sb.add_updates);
    if (sb.mismatches == 0 && sb.expected_updates.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("mismatches %0d, outstanding %0d", sb.mismatches, sb.expected_updates.size());
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
